[rtl/lrn_pkg.sv]
// Shared types, constants and the 2^(2^-(i+1)) table for the channel LRN block.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package lrn_pkg;

	localparam int MAX_WINDOW   = 15;
	localparam int SAMPLE_W     = 16;
	localparam int SUM_W        = 36;
	localparam int CNT_W        = 5;
	localparam int PEND_W       = 4;
	localparam int RING_PTR_W   = 4;
	localparam int RING_DEPTH   = 1 << RING_PTR_W;
	localparam int FIFO_PTR_W   = 2;
	localparam int FIFO_DEPTH   = 1 << FIFO_PTR_W;
	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 32;

	// Register reset values
	localparam logic [3:0]  WINDOW_RST = 4'd5;
	localparam logic [23:0] ALPHA_RST  = 24'd20;
	localparam logic [15:0] BETA_RST   = 16'd12288;
	localparam logic [31:0] K_RST      = 32'd65536;

	// Register map, word index into the APB space
	typedef enum logic [1:0] {
		REG_WINDOW = 2'd0,
		REG_ALPHA  = 2'd1,
		REG_BETA   = 2'd2,
		REG_K      = 2'd3
	} lrn_reg_t;

	typedef struct packed {
		logic [3:0]  window_size;
		logic [23:0] alpha_scaled;
		logic [15:0] beta_exponent;
		logic [31:0] k_offset;
	} lrn_cfg_t;

	// One queued input item
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_channel;
	} lrn_item_t;

	// One normalization job handed to the power unit
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [SUM_W-1:0]           sum;
		logic                       last;
	} lrn_job_t;

	typedef logic [31:0] lrn_exp_tab_t [16];

	// Floor integer square root, evaluated at elaboration only
	function automatic logic [63:0] lrn_isqrt(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = x_in;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (b > x) b = b >> 2;
		end
		for (int k = 0; k < 32; k++) begin
			if (b != 64'd0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// T[i] = 2^(2^-(i+1)) in Q2.30, by repeated square roots of 2.0
	function automatic lrn_exp_tab_t lrn_build_exp_tab();
		lrn_exp_tab_t tab;
		logic [63:0]  v;
		v = 64'd2 << 30;
		for (int i = 0; i < 16; i++) begin
			v = lrn_isqrt(v << 30);
			tab[i] = v[31:0];
		end
		return tab;
	endfunction

	localparam lrn_exp_tab_t EXP_TAB = lrn_build_exp_tab();

endpackage

`default_nettype wire

[rtl/lrn_in_if.sv]
// Input channel of the LRN block: valid/ready plus one channel sample.
// Depends on lrn_pkg for field widths.
`default_nettype none

interface lrn_in_if;
	import lrn_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_channel;

	modport source (output valid, output sample, output last_channel, input ready);
	modport sink   (input valid, input sample, input last_channel, output ready);
endinterface

`default_nettype wire

[rtl/lrn_out_if.sv]
// Output channel of the LRN block: valid/ready plus one normalized value.
// Depends on lrn_pkg for field widths.
`default_nettype none

interface lrn_out_if;
	import lrn_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] normalized;
	logic                       last_of_vector;

	modport source (output valid, output normalized, output last_of_vector, input ready);
	modport sink   (input valid, input normalized, input last_of_vector, output ready);
endinterface

`default_nettype wire

[rtl/local_response_norm_channel.sv]
// Local response normalization across channels, Q8.8 in and out.
// Each accepted input passes the queue and the window sequencer; the power unit
// then forms the scale, normalizes it, runs 16 log2 steps and the exp2 steps,
// and multiplies and rounds; a zero sample skips straight to the output.
// The power unit takes one job at a time and takes the next only after its
// result has left the output; the 4-entry input queue keeps accepting meanwhile.
// Reset (arst_n low, async): control state clears, registers take defaults.
`default_nettype none

module local_response_norm_channel (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [lrn_pkg::PADDR_W-1:0]   paddr,
	input  wire [lrn_pkg::PDATA_W-1:0]   pwdata,
	output logic [lrn_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	lrn_in_if.sink                       in_item,
	lrn_out_if.source                    out_item
);
	import lrn_pkg::*;

	lrn_cfg_t   cfg_q;
	lrn_reg_t   reg_idx;
	logic       wr_en;
	logic       q_valid;
	lrn_item_t  q_item;
	logic       q_pop;
	logic       job_valid;
	lrn_job_t   job;
	logic       job_ready;

	assign pready  = 1'b1;
	assign reg_idx = lrn_reg_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_size   <= WINDOW_RST;
			cfg_q.alpha_scaled  <= ALPHA_RST;
			cfg_q.beta_exponent <= BETA_RST;
			cfg_q.k_offset      <= K_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WINDOW: cfg_q.window_size   <= pwdata[3:0];
				REG_ALPHA:  cfg_q.alpha_scaled  <= pwdata[23:0];
				REG_BETA:   cfg_q.beta_exponent <= pwdata[15:0];
				REG_K:      cfg_q.k_offset      <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back configuration
	always_comb begin
		unique case (reg_idx)
			REG_WINDOW: prdata = {28'b0, cfg_q.window_size};
			REG_ALPHA:  prdata = {8'b0, cfg_q.alpha_scaled};
			REG_BETA:   prdata = {16'b0, cfg_q.beta_exponent};
			REG_K:      prdata = cfg_q.k_offset;
			default:    prdata = '0;
		endcase
	end

	lrn_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_item),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	lrn_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.window_size (cfg_q.window_size),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.job_valid   (job_valid),
		.job         (job),
		.job_ready   (job_ready)
	);

	lrn_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (job_valid),
		.job       (job),
		.job_ready (job_ready),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

[rtl/lrn_front.sv]
// Front end: accepts input items and buffers them in a small queue.
// Depends on lrn_pkg and lrn_in_if.
`default_nettype none

module lrn_front (
	input  wire                 clk,
	input  wire                 arst_n,
	lrn_in_if.sink              in_item,
	output logic                q_valid,
	output lrn_pkg::lrn_item_t  q_item,
	input  wire                 q_pop
);
	import lrn_pkg::*;

	lrn_item_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_q;
	logic [FIFO_PTR_W-1:0]   rd_q;
	logic [FIFO_PTR_W:0]     count_q;
	logic                    push;

	assign in_item.ready = (count_q != (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign push          = in_item.valid && in_item.ready;
	assign q_valid       = (count_q != '0);
	assign q_item        = fifo_q[rd_q];

	// Store accepted items
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q].sample       <= in_item.sample;
			fifo_q[wr_q].last_channel <= in_item.last_channel;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			if (push && !q_pop) count_q <= count_q + 1'b1;
			else if (!push && q_pop) count_q <= count_q - 1'b1;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
		else $error("queue occupancy above depth");
	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue did not grow on push");
	a_full_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!in_item.ready |-> q_valid)
		else $error("full queue reports no item");
`endif

endmodule

`default_nettype wire

[rtl/lrn_window.sv]
// Back end sequencer: delay ring, running sum of squares and flush of
// owed results at the end of a vector. Depends on lrn_pkg.
`default_nettype none

module lrn_window (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire [3:0]           window_size,
	input  wire                 q_valid,
	input  lrn_pkg::lrn_item_t  q_item,
	output logic                q_pop,
	output logic                job_valid,
	output lrn_pkg::lrn_job_t   job,
	input  wire                 job_ready
);
	import lrn_pkg::*;

	typedef enum logic [2:0] {
		W_IDLE = 3'b001,
		W_FILL = 3'b010,
		W_CALC = 3'b100
	} win_state_t;

	win_state_t                 state_q;
	logic [RING_PTR_W-1:0]      wp_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [PEND_W-1:0]          pend_q;
	logic [SUM_W-1:0]           sum_q;
	logic [2:0]                 t_q;
	logic                       flush_q;
	logic                       last_q;
	logic signed [SAMPLE_W-1:0] v_q;
	logic signed [SAMPLE_W-1:0] old_rd_q;
	logic signed [SAMPLE_W-1:0] out_rd_q;
	logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];

	logic [3:0]                 w_eff;
	logic [2:0]                 post;
	logic [RING_PTR_W-1:0]      ra_old;
	logic [RING_PTR_W-1:0]      ra_out;
	logic                       load;
	logic signed [SAMPLE_W-1:0] ring_wd;
	logic signed [31:0]         sq_new_s;
	logic signed [31:0]         sq_old_s;
	logic [SUM_W:0]             s1;
	logic [SUM_W:0]             s2;
	logic                       drop;
	logic                       emit;
	logic                       t_last;
	logic                       end_vec;
	logic                       calc_go;

	// Effective window and trailing pad
	assign w_eff  = (window_size == 4'd0) ? 4'd1 : window_size;
	assign post   = w_eff[3:1];
	assign ra_old = wp_q - w_eff;
	assign ra_out = wp_q - {1'b0, post};

	assign q_pop   = (state_q == W_IDLE) && q_valid;
	assign load    = q_pop || (state_q == W_FILL);
	assign ring_wd = (state_q == W_IDLE) ? q_item.sample : '0;

	// Write the newest sample, fetch the dropped and the centered ones
	always_ff @(posedge clk) begin
		if (load) begin
			ring[wp_q] <= ring_wd;
			old_rd_q   <= ring[ra_old];
			out_rd_q   <= ring[ra_out];
		end
	end

	// Update the running sum
	assign sq_new_s = v_q * v_q;
	assign sq_old_s = old_rd_q * old_rd_q;
	assign s1       = {1'b0, sum_q} + {5'b0, sq_new_s};
	assign drop     = cnt_q >= {1'b0, w_eff};
	always_comb begin
		s2 = s1;
		if (drop) begin
			if (s1 >= {5'b0, sq_old_s}) s2 = s1 - {5'b0, sq_old_s};
			else s2 = '0;
		end
	end

	// Decide whether this slot emits a result
	assign t_last = (t_q == post - 3'd1);
	always_comb begin
		if (flush_q) begin
			emit    = ({2'b0, t_q} + {1'b0, pend_q}) >= {2'b0, post};
			end_vec = t_last;
		end else begin
			emit    = cnt_q >= {2'b0, post};
			end_vec = last_q && (post == 3'd0);
		end
	end

	assign calc_go    = (state_q == W_CALC) && (!emit || job_ready);
	assign job_valid  = (state_q == W_CALC) && emit;
	assign job.sample = (post == 3'd0) ? v_q : out_rd_q;
	assign job.sum    = s2[SUM_W-1:0];
	assign job.last   = flush_q ? t_last : (last_q && (post == 3'd0));

	// Hold the slot value
	always_ff @(posedge clk) begin
		if (load) v_q <= ring_wd;
	end

	// Sequence item and flush slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			wp_q    <= '0;
			cnt_q   <= '0;
			pend_q  <= '0;
			sum_q   <= '0;
			t_q     <= '0;
			flush_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				W_IDLE: begin
					if (q_valid) begin
						last_q  <= q_item.last_channel;
						flush_q <= 1'b0;
						state_q <= W_CALC;
					end
				end
				W_FILL: begin
					flush_q <= 1'b1;
					state_q <= W_CALC;
				end
				W_CALC: begin
					if (calc_go) begin
						wp_q  <= wp_q + 1'b1;
						sum_q <= s2[SUM_W-1:0];
						if (cnt_q != {CNT_W{1'b1}}) cnt_q <= cnt_q + 1'b1;
						if (!flush_q && !emit && pend_q != {PEND_W{1'b1}})
							pend_q <= pend_q + 1'b1;
						if (end_vec) begin
							cnt_q   <= '0;
							pend_q  <= '0;
							sum_q   <= '0;
							state_q <= W_IDLE;
						end else if (flush_q) begin
							t_q     <= t_q + 3'd1;
							state_q <= W_FILL;
						end else if (last_q) begin
							t_q     <= '0;
							state_q <= W_FILL;
						end else begin
							state_q <= W_IDLE;
						end
					end
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_pop_calc: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == W_CALC)
		else $error("popped item not processed");
	a_sum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == '0 |-> sum_q == '0)
		else $error("sum not clear at vector start");
	a_wp_step: assert property (@(posedge clk) disable iff (!arst_n)
		calc_go |=> wp_q == $past(wp_q) + RING_PTR_W'(1))
		else $error("ring pointer did not advance");
`endif

endmodule

`default_nettype wire

[rtl/lrn_norm.sv]
// Power unit: scale = k + alpha*sum, then sample * scale^(-beta) through
// iterative log2/exp2 and a rounding shift. Depends on lrn_pkg, lrn_out_if.
`default_nettype none

module lrn_norm (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lrn_pkg::lrn_cfg_t   cfg,
	input  wire                 job_valid,
	input  lrn_pkg::lrn_job_t   job,
	output logic                job_ready,
	lrn_out_if.source           out_item
);
	import lrn_pkg::*;

	typedef enum logic [10:0] {
		N_IDLE  = 11'b00000000001,
		N_MLO   = 11'b00000000010,
		N_MHI   = 11'b00000000100,
		N_SCALE = 11'b00000001000,
		N_NORM  = 11'b00000010000,
		N_LOG   = 11'b00000100000,
		N_EXPM  = 11'b00001000000,
		N_POW   = 11'b00010000000,
		N_MUL   = 11'b00100000000,
		N_FIN   = 11'b01000000000,
		N_OUT   = 11'b10000000000
	} norm_state_t;

	norm_state_t                state_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic [SUM_W-1:0]           sum_q;
	logic                       last_q;
	logic [41:0]                plo_q;
	logic [41:0]                phi_q;
	logic [36:0]                m_q;
	logic [5:0]                 e_q;
	logic [30:0]                mant_q;
	logic [15:0]                frac_q;
	logic [3:0]                 it_q;
	logic signed [40:0]         prodb_q;
	logic [31:0]                fac_q;
	logic [47:0]                p_q;
	logic [SAMPLE_W-1:0]        res_q;

	logic [59:0]                full;
	logic [36:0]                scale;
	logic [61:0]                sqp;
	logic [31:0]                sqv;
	logic signed [40:0]         lg_s;
	logic signed [40:0]         beta_s;
	logic signed [40:0]         bprod;
	logic [15:0]                fpart;
	logic [63:0]                fm;
	logic                       neg;
	logic [16:0]                mag17;
	logic [SAMPLE_W-1:0]        mag;
	logic signed [12:0]         sh;
	logic signed [12:0]         nsh;
	logic [63:0]                limit;
	logic [63:0]                r;
	logic [SAMPLE_W-1:0]        sat_res;
	logic [SAMPLE_W-1:0]        fin_res;

	assign job_ready               = (state_q == N_IDLE);
	assign out_item.valid          = (state_q == N_OUT);
	assign out_item.normalized     = res_q;
	assign out_item.last_of_vector = last_q;

	// Scale from the two partial products
	assign full  = {phi_q, 18'b0} + {18'b0, plo_q};
	assign scale = {5'b0, cfg.k_offset} + {1'b0, full[59:24]};

	// One squaring step of the log mantissa
	assign sqp = mant_q * mant_q;
	assign sqv = sqp[61:30];

	// Exponent -beta*(log2 - 16)
	assign lg_s   = 41'(signed'({19'b0, e_q, frac_q})) - 41'sd1048576;
	assign beta_s = 41'(signed'({25'b0, cfg.beta_exponent}));
	assign bprod  = beta_s * lg_s;

	// One product step of 2^f
	assign fpart = prodb_q[29:14];
	assign fm    = {32'b0, fac_q} * {32'b0, EXP_TAB[it_q]};

	// Magnitude and sign of the sample
	assign neg     = x_q[SAMPLE_W-1];
	assign mag17   = neg ? (17'd0 - {x_q[SAMPLE_W-1], x_q}) : {1'b0, x_q};
	assign mag     = mag17[SAMPLE_W-1:0];
	assign limit   = neg ? 64'd32768 : 64'd32767;
	assign sat_res = neg ? 16'h8000 : 16'h7FFF;

	// Rounding shift by 2^(n-30) and saturation; n is the signed integer part
	assign sh  = 13'sd30 - 13'(signed'(prodb_q[40:30]));
	assign nsh = 13'sd0 - sh;
	always_comb begin
		priority if (sh >= 13'sd63) begin
			r = 64'd0;
		end else if (sh > 13'sd0) begin
			r = ({16'b0, p_q} + (64'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];
		end else if (nsh >= 13'sd17) begin
			r = limit;
		end else begin
			r = {16'b0, p_q} << nsh[4:0];
		end
		if (r > limit) r = limit;
		fin_res = neg ? (16'd0 - r[15:0]) : r[15:0];
	end

	// Hold job and intermediate values
	always_ff @(posedge clk) begin
		unique case (state_q)
			N_IDLE: begin
				x_q    <= job.sample;
				sum_q  <= job.sum;
				last_q <= job.last;
				res_q  <= '0;
			end
			N_MLO:   plo_q <= {18'b0, sum_q[17:0]} * {18'b0, cfg.alpha_scaled};
			N_MHI:   phi_q <= {24'b0, sum_q[35:18]} * {18'b0, cfg.alpha_scaled};
			N_SCALE: begin
				m_q <= scale;
				e_q <= 6'd36;
			end
			N_NORM: begin
				if (m_q == '0) begin
					res_q <= (cfg.beta_exponent == '0) ? x_q : sat_res;
				end else if (m_q[36]) begin
					mant_q <= m_q[36:6];
					frac_q <= '0;
				end else begin
					m_q <= {m_q[35:0], 1'b0};
					e_q <= e_q - 6'd1;
				end
			end
			N_LOG: begin
				if (sqv[31]) begin
					mant_q       <= sqv[31:1];
					frac_q[it_q] <= 1'b1;
				end else begin
					mant_q <= sqv[30:0];
				end
			end
			N_EXPM: begin
				prodb_q <= 41'sd0 - bprod;
				fac_q   <= 32'd1 << 30;
			end
			N_POW: begin
				if (fpart[4'd15 - it_q]) fac_q <= fm[61:30];
			end
			N_MUL: p_q   <= {32'b0, mag} * {16'b0, fac_q};
			N_FIN: res_q <= fin_res;
			N_OUT: ;
			default: ;
		endcase
	end

	// Step the unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			it_q    <= '0;
		end else begin
			unique case (state_q)
				N_IDLE: begin
					if (job_valid) state_q <= (job.sample == '0) ? N_OUT : N_MLO;
				end
				N_MLO:   state_q <= N_MHI;
				N_MHI:   state_q <= N_SCALE;
				N_SCALE: state_q <= N_NORM;
				N_NORM: begin
					if (m_q == '0) begin
						state_q <= N_OUT;
					end else if (m_q[36]) begin
						it_q    <= 4'd15;
						state_q <= N_LOG;
					end
				end
				N_LOG: begin
					if (it_q == 4'd0) state_q <= N_EXPM;
					else it_q <= it_q - 4'd1;
				end
				N_EXPM: begin
					it_q    <= 4'd0;
					state_q <= N_POW;
				end
				N_POW: begin
					if (it_q == 4'd15) state_q <= N_MUL;
					else it_q <= it_q + 4'd1;
				end
				N_MUL: state_q <= N_FIN;
				N_FIN: state_q <= N_OUT;
				N_OUT: begin
					if (out_item.ready) state_q <= N_IDLE;
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_job_start: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && job_ready) |=> state_q != N_IDLE)
		else $error("job taken but unit idle");
	a_log_norm: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == N_LOG |-> m_q[36])
		else $error("log started on unnormalized scale");
	a_fac_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == N_POW |-> (!fac_q[31] && fac_q[30]))
		else $error("2^f factor out of [1,2)");
`endif

endmodule

`default_nettype wire

[bench/local_response_norm_channel_tb.sv]
// Self-checking testbench for local_response_norm_channel: directed rows, then random
// vectors over several register settings. Predicts every result internally.
// Depends on rtl/lrn_pkg.sv, rtl/lrn_in_if.sv, rtl/lrn_out_if.sv and the block itself.
`default_nettype none

module local_response_norm_channel_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lrn_pkg::*;

	localparam int DRAIN_CYCLES = 120;
	localparam logic [63:0] SUM_MASK = (64'd1 << SUM_W) - 64'd1;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;

	typedef struct packed {
		logic [15:0] normalized;
		logic        last;
	} lrn_result_t;

	typedef struct packed {
		logic [15:0] smp;
		logic        last;
		logic        typed;
		logic [15:0] want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	lrn_in_if  in_bus();
	lrn_out_if out_bus();

	local_response_norm_channel dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_item(in_bus), .out_item(out_bus)
	);

	// register copies
	logic [3:0]  win_reg;
	logic [23:0] alpha_reg;
	logic [15:0] beta_reg;
	logic [31:0] k_reg;

	// window state
	logic [15:0] delay_line [MAX_WINDOW];
	logic [63:0] sq_sum;
	int          chan_count;
	int          owed;
	logic [63:0] pow_tab [16];

	lrn_result_t expected_q [$];
	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int hold_left = 0;
	bit hold_req = 0;
	bit no_gaps = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [63:0] floor_sqrt(input logic [63:0] x_in);
		logic [63:0] x, r, b;
		x = x_in;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] square16(input logic [15:0] v);
		longint x;
		x = longint'($signed(v));
		return 64'(x * x);
	endfunction

	function automatic logic [31:0] log2_fix(input logic [63:0] s);
		int e;
		logic [31:0] frac;
		logic [63:0] m;
		e = 0;
		frac = 0;
		while (e < 63 && (s >> (e + 1)) != 0) e++;
		m = (e >= 30) ? (s >> (e - 30)) : (s << (30 - e));
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= 2 * Q30_ONE) begin
				m = m >> 1;
				frac[i] = 1'b1;
			end
		end
		return (32'(e) << 16) | frac;
	endfunction

	// sample * (k + alpha*sum)^(-beta), saturated Q8.8
	function automatic logic [15:0] normalize_value(input logic [15:0] v, input logic [63:0] sum);
		longint x, lg, prod, n, sh;
		logic [63:0] scale, e16, f, fac, mag, p, r, lim;
		x = longint'($signed(v));
		if (x == 0) return 16'h0000;
		scale = 64'(k_reg) + (((sum & SUM_MASK) * 64'(alpha_reg)) >> 24);
		if (scale == 0) begin
			if (beta_reg == 0) return v;
			return x > 0 ? 16'h7FFF : 16'h8000;
		end
		lg = longint'(log2_fix(scale)) - (longint'(16) << 16);
		prod = -longint'(beta_reg) * lg;
		e16 = 64'(prod + (longint'(1) << 40)) >> 14;
		f = e16 & 64'hFFFF;
		n = longint'(e16 >> 16) - 1024;
		fac = Q30_ONE;
		for (int i = 0; i < 16; i++)
			if (f[15-i]) fac = (fac * pow_tab[i]) >> 30;
		mag = 64'(x > 0 ? x : -x);
		p = mag * fac;
		sh = 30 - n;
		lim = x > 0 ? 64'd32767 : 64'd32768;
		if (sh >= 63) r = 0;
		else if (sh > 0) r = (p + (64'd1 << (sh - 1))) >> sh;
		else if (-sh >= 17) r = lim;
		else r = p << (-sh);
		if (r > lim) r = lim;
		if (x > 0) return r[15:0];
		return 16'(17'h10000 - r[16:0]);
	endfunction

	function automatic void push_sample(input logic [15:0] v);
		for (int i = MAX_WINDOW - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
		delay_line[0] = v;
	endfunction

	function automatic logic [63:0] drop_square(input logic [63:0] sum, input int w);
		logic [63:0] old;
		old = square16(delay_line[w-1]);
		return sum >= old ? sum - old : 64'd0;
	endfunction

	// advance the window by one accepted item and queue the results it owes
	function automatic void predict_item(input logic [15:0] v, input logic last);
		int w, post, head, cnt;
		logic [63:0] sum;
		lrn_result_t res;
		w = (win_reg == 0) ? 1 : int'(win_reg);
		post = (w - 1) - (w - 1) / 2;
		head = chan_count;
		cnt = 0;
		sum = sq_sum + square16(v);
		if (head >= w) sum = drop_square(sum, w);
		push_sample(v);
		sum = sum & SUM_MASK;
		chan_count = (head + 1 > 31) ? 31 : head + 1;
		if (head >= post) begin
			res.normalized = normalize_value(delay_line[post], sum);
			res.last = last && post == 0;
			expected_q.push_back(res);
			cnt = 1;
		end else if (owed < 15) begin
			owed++;
		end
		if (last) begin
			// flush the results still owed
			for (int t = 0; t < post; t++) begin
				if (head + 1 + t >= w) sum = drop_square(sum, w);
				push_sample(16'h0000);
				if (post - t <= owed && cnt < 8) begin
					res.normalized = normalize_value(delay_line[post], sum);
					res.last = (t == post - 1);
					expected_q.push_back(res);
					cnt++;
				end
			end
			chan_count = 0;
			owed = 0;
			sum = 0;
		end
		sq_sum = sum;
	endfunction

	function automatic int gap_len();
		int r;
		if (no_gaps) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [15:0] rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'h0000;
		if (r < 3) return 16'($urandom);
		if (r < 6) return 16'($signed($urandom_range(0, 1023)) - 512);
		if (r < 8) return 16'($signed($urandom_range(0, 8191)) - 4096);
		return $urandom_range(0, 1) ? 16'h7FFF - 16'($urandom_range(0, 3))
			: 16'h8000 + 16'($urandom_range(0, 3));
	endfunction

	// offer one item, predict on acceptance; valid stays high afterward
	task automatic send_item(input logic [15:0] v, input logic last, output bit pushed);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_bus.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.sample <= v;
		in_bus.last_channel <= last;
		do @(posedge clk); while (!in_bus.ready);
		predict_item(v, last);
		items_sent++;
		pushed = 1;
	endtask

	task automatic write_reg(input lrn_reg_t idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_WINDOW: win_reg = value[3:0];
			REG_ALPHA: alpha_reg = value[23:0];
			REG_BETA: beta_reg = value[15:0];
			REG_K: k_reg = value;
		endcase
	endtask

	task automatic wait_drained();
		in_bus.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(input logic [3:0] w, input logic [23:0] a,
			input logic [15:0] b, input logic [31:0] k);
		wait_drained();
		write_reg(REG_WINDOW, 32'(w));
		write_reg(REG_ALPHA, 32'(a));
		write_reg(REG_BETA, 32'(b));
		write_reg(REG_K, k);
	endtask

	// one vector of the given length with random samples; last flag on its final item
	task automatic send_vector(input int len);
		bit dummy;
		for (int i = 0; i < len; i++) send_item(rand_sample(), i == len - 1, dummy);
	endtask

	// sink side: random stalls, plus one long hold-off on request
	initial begin
		int r;
		out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = 600;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_bus.ready <= 1'b0;
			end else if (no_gaps) begin
				out_bus.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r >= 97) hold_left = $urandom_range(10, 60);
				out_bus.ready <= (r < 85);
			end
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		lrn_result_t want;
		if (arst_n && out_bus.valid && out_bus.ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h last %b", out_bus.normalized,
						out_bus.last_of_vector);
			end else begin
				want = expected_q.pop_front();
				if (want.normalized !== out_bus.normalized ||
						want.last !== out_bus.last_of_vector) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected %h last %b, got %h last %b",
							results_seen, want.normalized, want.last,
							out_bus.normalized, out_bus.last_of_vector);
				end
			end
		end
	end

	initial begin
		#10ms;
		$display("local_response_norm_channel_tb NOT OK");
		$finish;
	end

	initial begin
		stim_row_t rows [$];
		bit pushed;
		logic [63:0] v;
		rows = '{
			'{16'h0000, 1'b1, 1'b1, 16'h0000},
			'{16'h7FFF, 1'b0, 1'b0, 16'h0000},
			'{16'h8000, 1'b0, 1'b0, 16'h0000},
			'{16'h0100, 1'b0, 1'b0, 16'h0000},
			'{16'hFF00, 1'b0, 1'b0, 16'h0000},
			'{16'h0001, 1'b0, 1'b0, 16'h0000},
			'{16'hFFFF, 1'b1, 1'b0, 16'h0000},
			'{16'h0200, 1'b1, 1'b0, 16'h0000},
			'{16'h8000, 1'b0, 1'b0, 16'h0000},
			'{16'h7FFF, 1'b1, 1'b0, 16'h0000},
			'{16'h5555, 1'b0, 1'b0, 16'h0000},
			'{16'hAAAA, 1'b0, 1'b0, 16'h0000},
			'{16'h0000, 1'b0, 1'b0, 16'h0000},
			'{16'h1234, 1'b0, 1'b0, 16'h0000},
			'{16'hEDCB, 1'b0, 1'b0, 16'h0000},
			'{16'h0080, 1'b0, 1'b0, 16'h0000},
			'{16'h7000, 1'b0, 1'b0, 16'h0000},
			'{16'h9000, 1'b1, 1'b0, 16'h0000}
		};

		// hold everything known through reset
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_bus.valid <= 1'b0;
		in_bus.sample <= '0;
		in_bus.last_channel <= 1'b0;
		win_reg = WINDOW_RST;
		alpha_reg = ALPHA_RST;
		beta_reg = BETA_RST;
		k_reg = K_RST;
		sq_sum = 0;
		chan_count = 0;
		owed = 0;
		for (int i = 0; i < MAX_WINDOW; i++) delay_line[i] = 16'h0000;
		v = 64'd2 << 30;
		for (int i = 0; i < 16; i++) begin
			v = floor_sqrt(v << 30);
			pow_tab[i] = v;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows under the reset settings
		foreach (rows[i]) begin
			send_item(rows[i].smp, rows[i].last, pushed);
			if (rows[i].typed) expected_q[$].normalized = rows[i].want;
		end

		// register extremes and special settings, each followed by random vectors
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: load_config(4'd0, 24'hFFFFFF, 16'hFFFF, 32'd0);
				1: load_config(4'd15, 24'd0, 16'd0, 32'd0);
				2: load_config(4'd7, 24'd0, 16'd12288, 32'd0);
				3: load_config(4'd1, 24'd1000, 16'd16384, 32'd1);
				4: load_config(4'd15, 24'hFFFFFF, 16'd0, 32'hFFFFFFFF);
				5: load_config(4'd2, 24'd20, 16'hFFFF, 32'hFFFFFFFF);
				6: load_config(WINDOW_RST, ALPHA_RST, BETA_RST, K_RST);
				default: load_config(4'($urandom_range(0, 15)), 24'($urandom),
					16'($urandom), $urandom_range(0, 1) ? $urandom : $urandom_range(0, 131072));
			endcase
			no_gaps = (ph % 4 == 3);
			if (ph == 6) begin
				// long sink hold-off while items keep coming
				hold_req = 1;
				send_vector(20);
				send_vector(12);
			end
			for (int n = 0; n < 30; ) begin
				int len;
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
					: $urandom_range(1, 6);
				send_vector(len);
				n += len;
			end
		end
		no_gaps = 0;
		wait_drained();

		$display("run covered %0d items and %0d results over 13 register settings",
			items_sent, results_seen);
		if (mismatches == 0) begin
			$display("local_response_norm_channel_tb OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("local_response_norm_channel_tb NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
rtl/lrn_pkg.sv
rtl/lrn_in_if.sv
rtl/lrn_out_if.sv
rtl/lrn_front.sv
rtl/lrn_window.sv
rtl/lrn_norm.sv
rtl/local_response_norm_channel.sv
bench/local_response_norm_channel_tb.sv
